// ----- design/lcdm_pkg.sv -----
package lcdm_pkg;

	// Operation codes of an input item.
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// Display modes as held in STAT bits 1..0.
	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} mode_t;

	// Register addresses.
	localparam logic [15:0] ADDR_LCDC = 16'hFF40;
	localparam logic [15:0] ADDR_STAT = 16'hFF41;
	localparam logic [15:0] ADDR_SCY  = 16'hFF42;
	localparam logic [15:0] ADDR_SCX  = 16'hFF43;
	localparam logic [15:0] ADDR_LY   = 16'hFF44;
	localparam logic [15:0] ADDR_LYC  = 16'hFF45;
	localparam logic [15:0] ADDR_BGP  = 16'hFF47;
	localparam logic [15:0] ADDR_OBP0 = 16'hFF48;
	localparam logic [15:0] ADDR_OBP1 = 16'hFF49;
	localparam logic [15:0] ADDR_WY   = 16'hFF4A;
	localparam logic [15:0] ADDR_WX   = 16'hFF4B;
	localparam logic [15:0] ADDR_BGPI = 16'hFF68;
	localparam logic [15:0] ADDR_BGPD = 16'hFF69;
	localparam logic [15:0] ADDR_OBPI = 16'hFF6A;
	localparam logic [15:0] ADDR_OBPD = 16'hFF6B;

	// Mode durations in dots.
	localparam logic [15:0] DOTS_OAM    = 16'd80;
	localparam logic [15:0] DOTS_XFER   = 16'd172;
	localparam logic [15:0] DOTS_HBLANK = 16'd204;
	localparam logic [15:0] DOTS_LINE   = 16'd456;
	localparam logic [15:0] DOTS_MAX    = 16'hFFFF;

	// Line numbers.
	localparam logic [7:0] LINE_VBLANK = 8'd144;
	localparam logic [7:0] LINE_LAST   = 8'd153;

	// Register reset values and masks.
	localparam logic [7:0] LCDC_RESET = 8'h90;
	localparam logic [7:0] BGP_RESET  = 8'hFC;
	localparam logic [7:0] OBP_RESET  = 8'hFF;
	localparam logic [7:0] STAT_WMASK = 8'hF8;
	localparam logic [7:0] BYTE_NONE  = 8'hFF;

	// One input item.
	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  tick_cycles;
		logic [15:0] address;
		logic [7:0]  write_data;
	} in_t;

	// One result item.
	typedef struct packed {
		logic [7:0] read_data;
		logic       bad_address;
		logic       stat_irq;
		logic       vblank_irq;
		logic       oam_load;
		logic       line_render;
		logic       hblank_dma_req;
		logic       frame_done;
		logic [1:0] mode;
		logic [7:0] current_line;
	} out_t;

	// Access to one colour palette memory.
	typedef struct packed {
		logic       en;
		logic       we;
		logic [7:0] index;
		logic [7:0] data;
	} mem_req_t;

	// Result of the register stage, with the memory read selection.
	typedef struct packed {
		out_t res;
		logic sel_bg;
		logic sel_obj;
	} rsp_t;

endpackage

// ----- design/lcdm_color_mem.sv -----
module lcdm_color_mem #(
	parameter int DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lcdm_pkg::mem_req_t  req,
	output logic [7:0]          rdata
);

	localparam int AW = $clog2(DEPTH);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       rdata_q;
	logic [AW-1:0]    addr;

	assign addr  = req.index[AW-1:0];
	assign rdata = rdata_q;

	// Storage array and registered read port.
	always_ff @(posedge clk) begin
		if (req.en && req.we) begin
			mem[addr] <= req.data;
		end
		if (req.en && !req.we) begin
			rdata_q <= valid_q[addr] ? mem[addr] : 8'h00;
		end
	end

	// Entry valid bits; an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.en && req.we) begin
			valid_q[addr] <= 1'b1;
		end
	end

endmodule

// ----- design/lcdm_regs.sv -----
module lcdm_regs #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               accept,
	input  lcdm_pkg::in_t      item,
	output lcdm_pkg::rsp_t     rsp,
	output lcdm_pkg::mem_req_t bg_req,
	output lcdm_pkg::mem_req_t obj_req
);

	localparam int IW = $clog2(DEPTH);

	logic        color_mode_q;
	logic [15:0] dot_q, dot_n;
	logic [7:0]  lcdc_q, lcdc_n;
	logic [7:0]  stat_q, stat_n;
	logic [7:0]  scy_q, scy_n;
	logic [7:0]  scx_q, scx_n;
	logic [7:0]  ly_q, ly_n;
	logic [7:0]  lyc_q, lyc_n;
	logic [7:0]  bgp_q, bgp_n;
	logic [7:0]  obp0_q, obp0_n;
	logic [7:0]  obp1_q, obp1_n;
	logic [7:0]  wy_q, wy_n;
	logic [7:0]  wx_q, wx_n;
	logic [7:0]  bgpi_q, bgpi_n;
	logic [7:0]  obpi_q, obpi_n;
	logic        level_q, level_n;

	logic [16:0] sum;
	logic [15:0] sat;
	logic        match;
	logic        src;
	logic [7:0]  ly_inc;
	logic [1:0]  mode_cur;

	// Auto-increment of a colour index when its top bit is set.
	function automatic logic [7:0] next_index(input logic [7:0] idx);
		logic [7:0] r;
		r = idx;
		if (idx[7]) begin
			r = {idx[7:IW], idx[IW-1:0] + 1'b1};
		end
		return r;
	endfunction

	assign sum      = {1'b0, dot_q} + {9'd0, item.tick_cycles};
	assign sat      = sum[16] ? lcdm_pkg::DOTS_MAX : sum[15:0];
	assign match    = (ly_q == lyc_q);
	assign mode_cur = stat_q[1:0];
	assign ly_inc   = ly_q + 8'd1;
	assign src      = (match && stat_q[6])
			|| (mode_cur == lcdm_pkg::MODE_HBLANK && stat_q[3])
			|| (mode_cur == lcdm_pkg::MODE_OAM && stat_q[5])
			|| (mode_cur == lcdm_pkg::MODE_VBLANK && (stat_q[4] || stat_q[5]));

	// Next register state and the result of the item.
	always_comb begin
		dot_n   = dot_q;
		lcdc_n  = lcdc_q;
		stat_n  = stat_q;
		scy_n   = scy_q;
		scx_n   = scx_q;
		ly_n    = ly_q;
		lyc_n   = lyc_q;
		bgp_n   = bgp_q;
		obp0_n  = obp0_q;
		obp1_n  = obp1_q;
		wy_n    = wy_q;
		wx_n    = wx_q;
		bgpi_n  = bgpi_q;
		obpi_n  = obpi_q;
		level_n = level_q;
		rsp     = '0;
		rsp.res.read_data = lcdm_pkg::BYTE_NONE;
		bg_req  = '0;
		obj_req = '0;
		bg_req.index  = bgpi_q;
		bg_req.data   = item.write_data;
		obj_req.index = obpi_q;
		obj_req.data  = item.write_data;

		case (lcdm_pkg::op_t'(item.operation))
			lcdm_pkg::OP_READ: begin
				case (item.address)
					lcdm_pkg::ADDR_LCDC: rsp.res.read_data = lcdc_q;
					lcdm_pkg::ADDR_STAT: rsp.res.read_data = stat_q;
					lcdm_pkg::ADDR_SCY:  rsp.res.read_data = scy_q;
					lcdm_pkg::ADDR_SCX:  rsp.res.read_data = scx_q;
					lcdm_pkg::ADDR_LY:   rsp.res.read_data = ly_q;
					lcdm_pkg::ADDR_LYC:  rsp.res.read_data = lyc_q;
					lcdm_pkg::ADDR_BGP:  rsp.res.read_data = bgp_q;
					lcdm_pkg::ADDR_OBP0: rsp.res.read_data = obp0_q;
					lcdm_pkg::ADDR_OBP1: rsp.res.read_data = obp1_q;
					lcdm_pkg::ADDR_WY:   rsp.res.read_data = wy_q;
					lcdm_pkg::ADDR_WX:   rsp.res.read_data = wx_q;
					lcdm_pkg::ADDR_BGPI: rsp.res.read_data = bgpi_q;
					lcdm_pkg::ADDR_OBPI: rsp.res.read_data = obpi_q;
					lcdm_pkg::ADDR_BGPD: begin
						bg_req.en  = 1'b1;
						rsp.sel_bg = 1'b1;
					end
					lcdm_pkg::ADDR_OBPD: begin
						obj_req.en  = 1'b1;
						rsp.sel_obj = 1'b1;
					end
					default: rsp.res.bad_address = 1'b1;
				endcase
			end
			lcdm_pkg::OP_WRITE: begin
				case (item.address)
					lcdm_pkg::ADDR_LCDC: lcdc_n = item.write_data;
					lcdm_pkg::ADDR_STAT: begin
						stat_n = (stat_q & ~lcdm_pkg::STAT_WMASK)
								| (item.write_data & lcdm_pkg::STAT_WMASK);
					end
					lcdm_pkg::ADDR_SCY:  scy_n  = item.write_data;
					lcdm_pkg::ADDR_SCX:  scx_n  = item.write_data;
					lcdm_pkg::ADDR_LY:   ly_n   = item.write_data;
					lcdm_pkg::ADDR_LYC:  lyc_n  = item.write_data;
					lcdm_pkg::ADDR_BGP:  bgp_n  = item.write_data;
					lcdm_pkg::ADDR_OBP0: obp0_n = item.write_data;
					lcdm_pkg::ADDR_OBP1: obp1_n = item.write_data;
					lcdm_pkg::ADDR_WY:   wy_n   = item.write_data;
					lcdm_pkg::ADDR_WX:   wx_n   = item.write_data;
					lcdm_pkg::ADDR_BGPI: bgpi_n = item.write_data;
					lcdm_pkg::ADDR_OBPI: obpi_n = item.write_data;
					lcdm_pkg::ADDR_BGPD: begin
						bg_req.en = 1'b1;
						bg_req.we = 1'b1;
						bgpi_n    = next_index(bgpi_q);
					end
					lcdm_pkg::ADDR_OBPD: begin
						obj_req.en = 1'b1;
						obj_req.we = 1'b1;
						obpi_n     = next_index(obpi_q);
					end
					default: rsp.res.bad_address = 1'b1;
				endcase
			end
			lcdm_pkg::OP_TICK: begin
				dot_n = sat;
				if (!lcdc_q[7]) begin
					// Display off: hold the sequencer at the top of the frame.
					dot_n       = '0;
					ly_n        = '0;
					stat_n[1:0] = lcdm_pkg::MODE_HBLANK;
				end else begin
					// STAT line and its rising edge.
					stat_n[2]        = match;
					level_n          = src;
					rsp.res.stat_irq = src && !level_q;
					// At most one mode transition.
					case (lcdm_pkg::mode_t'(mode_cur))
						lcdm_pkg::MODE_OAM: begin
							if (sat >= lcdm_pkg::DOTS_OAM) begin
								dot_n            = sat - lcdm_pkg::DOTS_OAM;
								rsp.res.oam_load = 1'b1;
								stat_n[1:0]      = lcdm_pkg::MODE_XFER;
							end
						end
						lcdm_pkg::MODE_XFER: begin
							if (sat >= lcdm_pkg::DOTS_XFER) begin
								dot_n                  = sat - lcdm_pkg::DOTS_XFER;
								rsp.res.line_render    = 1'b1;
								rsp.res.hblank_dma_req = color_mode_q;
								stat_n[1:0]            = lcdm_pkg::MODE_HBLANK;
							end
						end
						lcdm_pkg::MODE_HBLANK: begin
							if (sat >= lcdm_pkg::DOTS_HBLANK) begin
								dot_n = sat - lcdm_pkg::DOTS_HBLANK;
								ly_n  = ly_inc;
								if (ly_inc == lcdm_pkg::LINE_VBLANK) begin
									stat_n[1:0]        = lcdm_pkg::MODE_VBLANK;
									rsp.res.vblank_irq = 1'b1;
									rsp.res.frame_done = 1'b1;
								end else begin
									stat_n[1:0] = lcdm_pkg::MODE_OAM;
								end
							end
						end
						default: begin
							if (sat >= lcdm_pkg::DOTS_LINE) begin
								dot_n = sat - lcdm_pkg::DOTS_LINE;
								ly_n  = ly_inc;
								if (ly_inc > lcdm_pkg::LINE_LAST) begin
									stat_n[1:0] = lcdm_pkg::MODE_OAM;
									ly_n        = '0;
								end
							end
						end
					endcase
				end
			end
			default: begin
			end
		endcase

		rsp.res.mode         = stat_n[1:0];
		rsp.res.current_line = ly_n;
		if (!accept) begin
			bg_req.en  = 1'b0;
			obj_req.en = 1'b0;
		end
	end

	// Register file and timing state, updated on each accepted transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q   <= '0;
			lcdc_q  <= lcdm_pkg::LCDC_RESET;
			stat_q  <= '0;
			scy_q   <= '0;
			scx_q   <= '0;
			ly_q    <= '0;
			lyc_q   <= '0;
			bgp_q   <= lcdm_pkg::BGP_RESET;
			obp0_q  <= lcdm_pkg::OBP_RESET;
			obp1_q  <= lcdm_pkg::OBP_RESET;
			wy_q    <= '0;
			wx_q    <= '0;
			bgpi_q  <= '0;
			obpi_q  <= '0;
			level_q <= 1'b0;
		end else if (accept) begin
			dot_q   <= dot_n;
			lcdc_q  <= lcdc_n;
			stat_q  <= stat_n;
			scy_q   <= scy_n;
			scx_q   <= scx_n;
			ly_q    <= ly_n;
			lyc_q   <= lyc_n;
			bgp_q   <= bgp_n;
			obp0_q  <= obp0_n;
			obp1_q  <= obp1_n;
			wy_q    <= wy_n;
			wx_q    <= wx_n;
			bgpi_q  <= bgpi_n;
			obpi_q  <= obpi_n;
			level_q <= level_n;
		end
	end

	// Colour mode configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			color_mode_q <= cfg_wr_data;
		end
	end

endmodule

// ----- design/lcdm_out_fifo.sv -----
module lcdm_out_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lcdm_pkg::out_t push_data,
	output logic           space,
	output logic           out_valid,
	input  logic           out_stall,
	output lcdm_pkg::out_t out_data,
	output logic [1:0]     count
);

	lcdm_pkg::out_t buf_q [2];
	logic [1:0]     count_q;
	logic           rd_q;
	logic           wr_q;
	logic           pop;

	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign space     = (count_q != 2'd2) || pop;
	assign out_data  = buf_q[rd_q];
	assign count     = count_q;

	// Two-entry result buffer so a stalled result does not block new items.
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_q    <= 1'b0;
			wr_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/lcd_mode_timing_and_registers_core.sv -----
// Path: a result passes the read stage register, then the result buffer.
// Throughput: one item per cycle; register stage, colour memory read and a
// two-entry result buffer run in step, and input stalls only when both
// buffer entries and the read stage are full.
// Reset: asynchronous; control state to reset values at once, data regs not;
// unwritten colour memory entries read as zero, so no clearing pass is needed.
module lcd_mode_timing_and_registers_core #(
	parameter int COLOR_MEM_DEPTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic           cfg_wr_data,
	input  logic           in_valid,
	output logic           in_stall,
	input  lcdm_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output lcdm_pkg::out_t out_data
);

	logic               accept;
	logic               valid_s1;
	lcdm_pkg::rsp_t     rsp;
	lcdm_pkg::rsp_t     rsp_s1;
	lcdm_pkg::mem_req_t bg_req;
	lcdm_pkg::mem_req_t obj_req;
	logic [7:0]         bg_rdata;
	logic [7:0]         obj_rdata;
	logic               space;
	logic               push;
	lcdm_pkg::out_t     push_data;
	logic [1:0]         fifo_count;

	assign push     = valid_s1 && space;
	assign in_stall = valid_s1 && !space;
	assign accept   = in_valid && !in_stall;

	lcdm_regs #(
		.DEPTH(COLOR_MEM_DEPTH)
	) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.accept     (accept),
		.item       (in_data),
		.rsp        (rsp),
		.bg_req     (bg_req),
		.obj_req    (obj_req)
	);

	lcdm_color_mem #(
		.DEPTH(COLOR_MEM_DEPTH)
	) u_bg_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (bg_req),
		.rdata (bg_rdata)
	);

	lcdm_color_mem #(
		.DEPTH(COLOR_MEM_DEPTH)
	) u_obj_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (obj_req),
		.rdata (obj_rdata)
	);

	// Read stage: wait for the colour memory data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_s1 <= rsp;
		end
	end

	// Merge the colour memory data into the result.
	always_comb begin
		push_data = rsp_s1.res;
		if (rsp_s1.sel_bg) begin
			push_data.read_data = bg_rdata;
		end else if (rsp_s1.sel_obj) begin
			push_data.read_data = obj_rdata;
		end
	end

	lcdm_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.space    (space),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.count    (fifo_count)
	);

	// The input stalls only while the read stage holds an item.
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty read stage");

	// An accepted transfer always occupies the read stage next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted transfer lost from read stage");

	// The result buffer never overflows.
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count != 2'd3)
		else $error("result buffer overflow");

	// At most one colour memory is selected for a read.
	a_one_mem_sel: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !(rsp_s1.sel_bg && rsp_s1.sel_obj))
		else $error("both colour memories selected");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT = 150000;
	localparam int HOLD_CYCLES = 150;
	localparam int N_DIRECTED  = 28;
	localparam int N_PHASE     = 44;
	localparam int N_SATURATE  = 700;

	// Registers that the random part reads and writes.
	localparam logic [15:0] BUS_MAP [15] = '{
		lcdm_pkg::ADDR_LCDC, lcdm_pkg::ADDR_STAT, lcdm_pkg::ADDR_SCY, lcdm_pkg::ADDR_SCX,
		lcdm_pkg::ADDR_LY, lcdm_pkg::ADDR_LYC, lcdm_pkg::ADDR_BGP, lcdm_pkg::ADDR_OBP0,
		lcdm_pkg::ADDR_OBP1, lcdm_pkg::ADDR_WY, lcdm_pkg::ADDR_WX, lcdm_pkg::ADDR_BGPI,
		lcdm_pkg::ADDR_BGPD, lcdm_pkg::ADDR_OBPI, lcdm_pkg::ADDR_OBPD
	};

	typedef struct {
		lcdm_pkg::in_t  item;
		bit             pinned;
		lcdm_pkg::out_t want;
	} dir_row_t;

	typedef struct {
		bit             pinned;
		lcdm_pkg::out_t want;
	} pin_t;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           cfg_wr_en;
	logic           cfg_wr_data;
	logic           in_valid;
	logic           in_stall;
	lcdm_pkg::in_t  in_data;
	logic           out_valid;
	logic           out_stall = 1'b0;
	lcdm_pkg::out_t out_data;

	// Shadow copy of the block's state, advanced on every input transfer.
	logic        pred_color_mode;
	logic [15:0] pred_dots;
	logic [7:0]  pred_lcdc;
	logic [7:0]  pred_stat;
	logic [7:0]  pred_scy;
	logic [7:0]  pred_scx;
	logic [7:0]  pred_ly;
	logic [7:0]  pred_lyc;
	logic [7:0]  pred_bgp;
	logic [7:0]  pred_obp0;
	logic [7:0]  pred_obp1;
	logic [7:0]  pred_wy;
	logic [7:0]  pred_wx;
	logic [7:0]  pred_bg_index;
	logic [7:0]  pred_obj_index;
	logic [7:0]  pred_bg_mem [64];
	logic [7:0]  pred_obj_mem [64];
	logic        pred_stat_level;

	lcdm_pkg::out_t pending_lcd_results [$];
	pin_t           pinned_results [$];
	int             fails = 0;
	int             cycle_count = 0;
	int             sender_idle_pct = 0;
	int             stall_pct = 0;
	int             hold_requests = 0;
	int             hold_served = 0;
	int             hold_left = 0;

	// A result of a read, write or no-operation: no event pulses.
	function automatic lcdm_pkg::out_t bus_result(logic [7:0] rd, logic bad,
			lcdm_pkg::mode_t m, logic [7:0] line);
		lcdm_pkg::out_t r;
		r = '0;
		r.read_data = rd;
		r.bad_address = bad;
		r.mode = m;
		r.current_line = line;
		return r;
	endfunction

	dir_row_t directed_rows [N_DIRECTED] = '{
		'{'{lcdm_pkg::OP_READ, 8'd0, lcdm_pkg::ADDR_LCDC, 8'h00}, 1'b1,
			bus_result(lcdm_pkg::LCDC_RESET, 1'b0, lcdm_pkg::MODE_HBLANK, 8'd0)},
		'{'{lcdm_pkg::OP_READ, 8'd0, lcdm_pkg::ADDR_BGP, 8'h00}, 1'b1,
			bus_result(lcdm_pkg::BGP_RESET, 1'b0, lcdm_pkg::MODE_HBLANK, 8'd0)},
		'{'{lcdm_pkg::OP_READ, 8'd0, lcdm_pkg::ADDR_OBP1, 8'h00}, 1'b1,
			bus_result(lcdm_pkg::OBP_RESET, 1'b0, lcdm_pkg::MODE_HBLANK, 8'd0)},
		'{'{lcdm_pkg::OP_READ, 8'd0, 16'h0000, 8'h00}, 1'b1,
			bus_result(lcdm_pkg::BYTE_NONE, 1'b1, lcdm_pkg::MODE_HBLANK, 8'd0)},
		'{'{lcdm_pkg::OP_WRITE, 8'd0, 16'hFFFF, 8'h00}, 1'b1,
			bus_result(lcdm_pkg::BYTE_NONE, 1'b1, lcdm_pkg::MODE_HBLANK, 8'd0)},
		'{'{lcdm_pkg::OP_WRITE, 8'd0, 16'hFF46, 8'hAA}, 1'b1,
			bus_result(lcdm_pkg::BYTE_NONE, 1'b1, lcdm_pkg::MODE_HBLANK, 8'd0)},
		'{'{lcdm_pkg::OP_NOP, 8'hFF, lcdm_pkg::ADDR_LCDC, 8'h00}, 1'b1,
			bus_result(lcdm_pkg::BYTE_NONE, 1'b0, lcdm_pkg::MODE_HBLANK, 8'd0)},
		'{'{lcdm_pkg::OP_READ, 8'd0, lcdm_pkg::ADDR_LCDC, 8'h00}, 1'b1,
			bus_result(lcdm_pkg::LCDC_RESET, 1'b0, lcdm_pkg::MODE_HBLANK, 8'd0)},
		'{'{lcdm_pkg::OP_WRITE, 8'd0, lcdm_pkg::ADDR_STAT, 8'hFF}, 1'b1,
			bus_result(lcdm_pkg::BYTE_NONE, 1'b0, lcdm_pkg::MODE_HBLANK, 8'd0)},
		'{'{lcdm_pkg::OP_READ, 8'd0, lcdm_pkg::ADDR_STAT, 8'h00}, 1'b1,
			bus_result(lcdm_pkg::STAT_WMASK, 1'b0, lcdm_pkg::MODE_HBLANK, 8'd0)},
		'{'{lcdm_pkg::OP_TICK, 8'd255, 16'h0000, 8'h00}, 1'b0, '0},
		'{'{lcdm_pkg::OP_TICK, 8'd80, 16'h0000, 8'h00}, 1'b0, '0},
		'{'{lcdm_pkg::OP_TICK, 8'd172, 16'h0000, 8'h00}, 1'b0, '0},
		'{'{lcdm_pkg::OP_WRITE, 8'd0, lcdm_pkg::ADDR_BGPI, 8'hBF}, 1'b0, '0},
		'{'{lcdm_pkg::OP_WRITE, 8'd0, lcdm_pkg::ADDR_BGPD, 8'hA5}, 1'b0, '0},
		'{'{lcdm_pkg::OP_READ, 8'd0, lcdm_pkg::ADDR_BGPI, 8'h00}, 1'b1,
			bus_result(8'h80, 1'b0, lcdm_pkg::MODE_HBLANK, 8'd1)},
		'{'{lcdm_pkg::OP_READ, 8'd0, lcdm_pkg::ADDR_BGPD, 8'h00}, 1'b0, '0},
		'{'{lcdm_pkg::OP_WRITE, 8'd0, lcdm_pkg::ADDR_OBPI, 8'h3F}, 1'b0, '0},
		'{'{lcdm_pkg::OP_WRITE, 8'd0, lcdm_pkg::ADDR_OBPD, 8'h11}, 1'b0, '0},
		'{'{lcdm_pkg::OP_READ, 8'd0, lcdm_pkg::ADDR_OBPD, 8'h00}, 1'b0, '0},
		'{'{lcdm_pkg::OP_WRITE, 8'd0, lcdm_pkg::ADDR_LCDC, 8'h00}, 1'b0, '0},
		'{'{lcdm_pkg::OP_TICK, 8'd255, 16'h0000, 8'h00}, 1'b1,
			bus_result(lcdm_pkg::BYTE_NONE, 1'b0, lcdm_pkg::MODE_HBLANK, 8'd0)},
		'{'{lcdm_pkg::OP_WRITE, 8'd0, lcdm_pkg::ADDR_LY, lcdm_pkg::LINE_VBLANK - 8'd1},
			1'b0, '0},
		'{'{lcdm_pkg::OP_WRITE, 8'd0, lcdm_pkg::ADDR_LCDC, 8'h91}, 1'b0, '0},
		'{'{lcdm_pkg::OP_TICK, 8'd255, 16'h0000, 8'h00}, 1'b0, '0},
		'{'{lcdm_pkg::OP_WRITE, 8'd0, lcdm_pkg::ADDR_LY, lcdm_pkg::LINE_LAST}, 1'b0, '0},
		'{'{lcdm_pkg::OP_TICK, 8'd255, 16'h0000, 8'h00}, 1'b0, '0},
		'{'{lcdm_pkg::OP_TICK, 8'd255, 16'h0000, 8'h00}, 1'b0, '0}
	};

	lcd_mode_timing_and_registers_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Works out the result of one item and advances the shadow state.
	function automatic lcdm_pkg::out_t lcd_timing_predict(lcdm_pkg::in_t it);
		lcdm_pkg::out_t  r;
		logic [16:0]     dot_sum;
		lcdm_pkg::mode_t m;
		logic            match;
		logic            src;
		r = '0;
		r.read_data = lcdm_pkg::BYTE_NONE;
		case (lcdm_pkg::op_t'(it.operation))
			lcdm_pkg::OP_READ: begin
				case (it.address)
					lcdm_pkg::ADDR_LCDC: r.read_data = pred_lcdc;
					lcdm_pkg::ADDR_STAT: r.read_data = pred_stat;
					lcdm_pkg::ADDR_SCY:  r.read_data = pred_scy;
					lcdm_pkg::ADDR_SCX:  r.read_data = pred_scx;
					lcdm_pkg::ADDR_LY:   r.read_data = pred_ly;
					lcdm_pkg::ADDR_LYC:  r.read_data = pred_lyc;
					lcdm_pkg::ADDR_BGP:  r.read_data = pred_bgp;
					lcdm_pkg::ADDR_OBP0: r.read_data = pred_obp0;
					lcdm_pkg::ADDR_OBP1: r.read_data = pred_obp1;
					lcdm_pkg::ADDR_WY:   r.read_data = pred_wy;
					lcdm_pkg::ADDR_WX:   r.read_data = pred_wx;
					lcdm_pkg::ADDR_BGPI: r.read_data = pred_bg_index;
					lcdm_pkg::ADDR_BGPD: r.read_data = pred_bg_mem[pred_bg_index[5:0]];
					lcdm_pkg::ADDR_OBPI: r.read_data = pred_obj_index;
					lcdm_pkg::ADDR_OBPD: r.read_data = pred_obj_mem[pred_obj_index[5:0]];
					default:   r.bad_address = 1'b1;
				endcase
			end
			lcdm_pkg::OP_WRITE: begin
				case (it.address)
					lcdm_pkg::ADDR_LCDC: pred_lcdc = it.write_data;
					lcdm_pkg::ADDR_STAT: begin
						pred_stat = (pred_stat & ~lcdm_pkg::STAT_WMASK)
							| (it.write_data & lcdm_pkg::STAT_WMASK);
					end
					lcdm_pkg::ADDR_SCY:  pred_scy = it.write_data;
					lcdm_pkg::ADDR_SCX:  pred_scx = it.write_data;
					lcdm_pkg::ADDR_LY:   pred_ly = it.write_data;
					lcdm_pkg::ADDR_LYC:  pred_lyc = it.write_data;
					lcdm_pkg::ADDR_BGP:  pred_bgp = it.write_data;
					lcdm_pkg::ADDR_OBP0: pred_obp0 = it.write_data;
					lcdm_pkg::ADDR_OBP1: pred_obp1 = it.write_data;
					lcdm_pkg::ADDR_WY:   pred_wy = it.write_data;
					lcdm_pkg::ADDR_WX:   pred_wx = it.write_data;
					lcdm_pkg::ADDR_BGPI: pred_bg_index = it.write_data;
					lcdm_pkg::ADDR_BGPD: begin
						pred_bg_mem[pred_bg_index[5:0]] = it.write_data;
						if (pred_bg_index[7])
							pred_bg_index[5:0] = pred_bg_index[5:0] + 6'd1;
					end
					lcdm_pkg::ADDR_OBPI: pred_obj_index = it.write_data;
					lcdm_pkg::ADDR_OBPD: begin
						pred_obj_mem[pred_obj_index[5:0]] = it.write_data;
						if (pred_obj_index[7])
							pred_obj_index[5:0] = pred_obj_index[5:0] + 6'd1;
					end
					default:   r.bad_address = 1'b1;
				endcase
			end
			lcdm_pkg::OP_TICK: begin
				dot_sum = {1'b0, pred_dots} + 17'(it.tick_cycles);
				pred_dots = dot_sum[16] ? lcdm_pkg::DOTS_MAX : dot_sum[15:0];
				// Bit 7 of LCDC switches the display on.
				if (!pred_lcdc[7]) begin
					pred_dots = '0;
					pred_ly = '0;
					pred_stat[1:0] = lcdm_pkg::MODE_HBLANK;
				end else begin
					m = lcdm_pkg::mode_t'(pred_stat[1:0]);
					match = (pred_ly == pred_lyc);
					src = (match && pred_stat[6])
						|| (m == lcdm_pkg::MODE_HBLANK && pred_stat[3])
						|| (m == lcdm_pkg::MODE_OAM && pred_stat[5])
						|| (m == lcdm_pkg::MODE_VBLANK && (pred_stat[4] || pred_stat[5]));
					pred_stat[2] = match;
					r.stat_irq = src && !pred_stat_level;
					pred_stat_level = src;
					// At most one mode change per tick.
					case (m)
						lcdm_pkg::MODE_OAM: begin
							if (pred_dots >= lcdm_pkg::DOTS_OAM) begin
								pred_dots = pred_dots - lcdm_pkg::DOTS_OAM;
								r.oam_load = 1'b1;
								pred_stat[1:0] = lcdm_pkg::MODE_XFER;
							end
						end
						lcdm_pkg::MODE_XFER: begin
							if (pred_dots >= lcdm_pkg::DOTS_XFER) begin
								pred_dots = pred_dots - lcdm_pkg::DOTS_XFER;
								r.line_render = 1'b1;
								r.hblank_dma_req = pred_color_mode;
								pred_stat[1:0] = lcdm_pkg::MODE_HBLANK;
							end
						end
						lcdm_pkg::MODE_HBLANK: begin
							if (pred_dots >= lcdm_pkg::DOTS_HBLANK) begin
								pred_dots = pred_dots - lcdm_pkg::DOTS_HBLANK;
								pred_ly = pred_ly + 8'd1;
								if (pred_ly == lcdm_pkg::LINE_VBLANK) begin
									pred_stat[1:0] = lcdm_pkg::MODE_VBLANK;
									r.vblank_irq = 1'b1;
									r.frame_done = 1'b1;
								end else begin
									pred_stat[1:0] = lcdm_pkg::MODE_OAM;
								end
							end
						end
						default: begin
							if (pred_dots >= lcdm_pkg::DOTS_LINE) begin
								pred_dots = pred_dots - lcdm_pkg::DOTS_LINE;
								pred_ly = pred_ly + 8'd1;
								if (pred_ly > lcdm_pkg::LINE_LAST) begin
									pred_stat[1:0] = lcdm_pkg::MODE_OAM;
									pred_ly = '0;
								end
							end
						end
					endcase
				end
			end
			default: ;
		endcase
		r.mode = pred_stat[1:0];
		r.current_line = pred_ly;
		return r;
	endfunction

	task automatic check_lcd_result(lcdm_pkg::out_t want, lcdm_pkg::out_t got);
		if (got.read_data !== want.read_data) begin
			$error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
			fails++;
		end
		if (got.bad_address !== want.bad_address) begin
			$error("bad_address: expected %0b, got %0b", want.bad_address, got.bad_address);
			fails++;
		end
		if (got.stat_irq !== want.stat_irq) begin
			$error("stat_irq: expected %0b, got %0b", want.stat_irq, got.stat_irq);
			fails++;
		end
		if (got.vblank_irq !== want.vblank_irq) begin
			$error("vblank_irq: expected %0b, got %0b", want.vblank_irq, got.vblank_irq);
			fails++;
		end
		if (got.oam_load !== want.oam_load) begin
			$error("oam_load: expected %0b, got %0b", want.oam_load, got.oam_load);
			fails++;
		end
		if (got.line_render !== want.line_render) begin
			$error("line_render: expected %0b, got %0b", want.line_render, got.line_render);
			fails++;
		end
		if (got.hblank_dma_req !== want.hblank_dma_req) begin
			$error("hblank_dma_req: expected %0b, got %0b", want.hblank_dma_req,
				got.hblank_dma_req);
			fails++;
		end
		if (got.frame_done !== want.frame_done) begin
			$error("frame_done: expected %0b, got %0b", want.frame_done, got.frame_done);
			fails++;
		end
		if (got.mode !== want.mode) begin
			$error("mode: expected %0d, got %0d", want.mode, got.mode);
			fails++;
		end
		if (got.current_line !== want.current_line) begin
			$error("current_line: expected %0d, got %0d", want.current_line, got.current_line);
			fails++;
		end
	endtask

	// Watches both channels and the configuration port at every rising edge.
	always @(posedge clk) begin
		lcdm_pkg::out_t want;
		pin_t           pin;
		if (arst_n) begin
			if (cfg_wr_en)
				pred_color_mode = cfg_wr_data;
			if (in_valid && !in_stall) begin
				want = lcd_timing_predict(in_data);
				pin = pinned_results.pop_front();
				if (pin.pinned)
					want = pin.want;
				pending_lcd_results.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (pending_lcd_results.size() == 0) begin
					$error("result transfer with no expectation waiting");
					fails++;
				end else begin
					check_lcd_result(pending_lcd_results.pop_front(), out_data);
				end
			end
		end
	end

	// Result side: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_served != hold_requests) begin
			hold_served = hold_served + 1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Offers one item after a random gap and returns at the edge of its transfer.
	task automatic send_lcd_item(lcdm_pkg::in_t it, bit pinned, lcdm_pkg::out_t want);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		pinned_results.push_back('{pinned, want});
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic wait_lcd_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_lcd_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_color_mode(logic value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Mostly ticks and accesses to real registers, with data shaped so that
	// the display stays on and the line sequencer reaches vblank and LYC matches.
	function automatic lcdm_pkg::in_t random_lcd_item();
		lcdm_pkg::in_t it;
		int            pick;
		it.operation = 2'($urandom_range(3));
		it.tick_cycles = 8'($urandom_range(255));
		it.address = 16'($urandom_range(16'hFFFF));
		it.write_data = 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 45) begin
			it.operation = lcdm_pkg::OP_TICK;
		end else if (pick < 85) begin
			it.operation = (pick < 65) ? lcdm_pkg::OP_WRITE : lcdm_pkg::OP_READ;
			it.address = BUS_MAP[$urandom_range(14)];
			if (it.address == lcdm_pkg::ADDR_LCDC && $urandom_range(99) < 85)
				it.write_data[7] = 1'b1;
			if ((it.address == lcdm_pkg::ADDR_LYC || it.address == lcdm_pkg::ADDR_LY)
					&& $urandom_range(99) < 80)
				it.write_data = 8'($urandom_range(lcdm_pkg::LINE_LAST));
		end else if (pick < 93) begin
			it.operation = $urandom_range(1) ? lcdm_pkg::OP_WRITE : lcdm_pkg::OP_READ;
		end else begin
			it.operation = lcdm_pkg::OP_NOP;
		end
		return it;
	endfunction

	task automatic run_random_phase(int idle, int stall, bit with_hold);
		sender_idle_pct = idle;
		stall_pct = stall;
		for (int k = 0; k < N_PHASE; k++) begin
			if (with_hold && k == N_PHASE / 4)
				hold_requests = hold_requests + 1;
			send_lcd_item(random_lcd_item(), 1'b0, '0);
		end
		wait_lcd_idle();
	endtask

	initial begin
		lcdm_pkg::in_t it;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		pred_color_mode = 1'b0;
		pred_dots = '0;
		pred_lcdc = lcdm_pkg::LCDC_RESET;
		pred_stat = '0;
		pred_scy = '0;
		pred_scx = '0;
		pred_ly = '0;
		pred_lyc = '0;
		pred_bgp = lcdm_pkg::BGP_RESET;
		pred_obp0 = lcdm_pkg::OBP_RESET;
		pred_obp1 = lcdm_pkg::OBP_RESET;
		pred_wy = '0;
		pred_wx = '0;
		pred_bg_index = '0;
		pred_obj_index = '0;
		pred_stat_level = 1'b0;
		for (int i = 0; i < 64; i++) begin
			pred_bg_mem[i] = '0;
			pred_obj_mem[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with hblank DMA requests enabled.
		write_color_mode(1'b1);
		for (int i = 0; i < N_DIRECTED; i++)
			send_lcd_item(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].want);
		wait_lcd_idle();

		// Random phases; the first one holds the result side off for a long stretch.
		write_color_mode(1'b0);
		run_random_phase(0, 0, 1'b1);
		write_color_mode(1'b1);
		run_random_phase(62, 0, 1'b0);
		write_color_mode(1'b0);
		run_random_phase(0, 62, 1'b0);
		write_color_mode(1'b1);
		run_random_phase(28, 28, 1'b0);

		// Long runs of full ticks drive the dot counter into saturation; LY is
		// pulled back now and then so that vblank never drains it.
		sender_idle_pct = 0;
		stall_pct = 28;
		for (int k = 0; k < N_SATURATE; k++) begin
			it = random_lcd_item();
			if (k == 0) begin
				it.operation = lcdm_pkg::OP_WRITE;
				it.address = lcdm_pkg::ADDR_LCDC;
				it.write_data[7] = 1'b1;
			end else if (k % 40 == 0) begin
				it.operation = lcdm_pkg::OP_WRITE;
				it.address = lcdm_pkg::ADDR_LY;
				it.write_data = '0;
			end else begin
				it.operation = lcdm_pkg::OP_TICK;
				it.tick_cycles = 8'd255;
			end
			send_lcd_item(it, 1'b0, '0);
		end
		wait_lcd_idle();

		write_color_mode(1'b0);
		run_random_phase(28, 28, 1'b0);

		repeat (10) @(posedge clk);
		if (fails == 0 && pending_lcd_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
